// File: rtl/signed_128bit_alu_top_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the signed 128-bit alu
// concurrent checks on i_clk, switched off by defining ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef SIGNED_128BIT_ALU_TOP_ASSERT_SVH
`define SIGNED_128BIT_ALU_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SALU_ASSERT(lbl, expr) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (expr)) else $error("salu assertion failed");
`define SALU_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (pre) |=> (post)) else $error("salu assertion failed");
`else
`define SALU_ASSERT(lbl, expr)
`define SALU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/salu_pkg.sv
// ---------------------------------------------------------------------------
// salu_pkg
// shared types and constants of the signed 128-bit alu
// ---------------------------------------------------------------------------
package salu_pkg;

    localparam int W = 128;

    typedef enum logic [3:0] {
        MODE_ADD = 4'd0,
        MODE_SUB = 4'd1,
        MODE_MUL = 4'd2,
        MODE_DIV = 4'd3,
        MODE_AND = 4'd4,
        MODE_OR  = 4'd5,
        MODE_XOR = 4'd6,
        MODE_NOT = 4'd7,
        MODE_SHL = 4'd8,
        MODE_SHR = 4'd9,
        MODE_ROL = 4'd10,
        MODE_ROR = 4'd11,
        MODE_CMP = 4'd12
    } t_mode;

    // one item in flight through the divide steps
    typedef struct packed {
        t_mode          mode;
        logic [W-1:0]   res;
        logic           lt;
        logic           eq;
        logic           gt;
        logic           dz;
        logic [W-1:0]   q;
        logic [W-1:0]   rem;
        logic [W-1:0]   m;
        logic           neg;
    } t_rec;

endpackage

// File: rtl/salu_div_step.sv
// ---------------------------------------------------------------------------
// salu_div_step
// one registered restoring divide iteration, other modes pass through
// ---------------------------------------------------------------------------
module salu_div_step
    import salu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_rec i_rec,
    output logic o_valid,
    output t_rec o_rec
);

    logic         r_valid;
    t_rec         r_rec;
    t_rec         n_rec;
    logic [W-1:0] w_rem;
    logic [W:0]   w_diff;

    always_comb begin
        n_rec  = i_rec;
        w_rem  = {i_rec.rem[W-2:0], i_rec.q[W-1]};
        w_diff = {1'b0, w_rem} - {1'b0, i_rec.m};
        if (i_rec.mode == MODE_DIV) begin
            n_rec.q   = {i_rec.q[W-2:0], ~w_diff[W]};
            n_rec.rem = w_diff[W] ? w_rem : w_diff[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rec <= n_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

// File: rtl/signed_128bit_alu_top.sv
// ---------------------------------------------------------------------------
// signed_128bit_alu_top
// pipelined 128-bit two's-complement alu with multiply and signed divide
// ---------------------------------------------------------------------------
// Takes one beat per cycle while the pipe is not stalled and returns one result
// beat for each, in order: an input register, an operand stage that
// forms the simple results, divide magnitudes and the 32x32 multiply
// partial products, two stages that sum the products, 128 divide stages
// with one restoring iteration each, and a final stage that applies the
// quotient sign and drives the output register. The divide chain sets the
// latency. The whole pipe moves together: it stalls only while a result
// beat waits at the output and the sink holds tready low; empty slots in
// the pipe keep flowing otherwise.
`include "signed_128bit_alu_top_assert.svh"

module signed_128bit_alu_top
    import salu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_hi, a_lo, b_hi, b_lo, shift_amount
    input  logic [263:0] i_s_axis_tdata,
    // mode
    input  logic [3:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_hi, result_lo
    output logic [127:0] o_m_axis_tdata,
    // less, equal, greater, divide_by_zero
    output logic [3:0]   o_m_axis_tuser
);

    logic w_en;

    // input stage
    logic         r1_v;
    t_mode        r1_mode;
    logic [W-1:0] r1_a;
    logic [W-1:0] r1_b;
    logic [7:0]   r1_amt;

    // operand stage
    logic         r2_v;
    t_rec         r2_rec;
    t_rec         n2_rec;
    logic [63:0]  r2_p [10];
    logic [63:0]  n2_p [10];

    // partial sums by limb weight
    logic         r3_v;
    t_rec         r3_rec;
    logic [63:0]  r3_s0;
    logic [64:0]  r3_s1;
    logic [65:0]  r3_s2;
    logic [31:0]  r3_s3;

    // product done
    logic         r4_v;
    t_rec         r4_rec;
    t_rec         n4_rec;
    logic [W-1:0] n4_prod;

    logic         w_v   [W+1];
    t_rec         w_rec [W+1];

    // output register
    logic         r_out_v;
    logic [127:0] r_out_data;
    logic [3:0]   r_out_user;
    logic [W-1:0] n_out_res;

    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r1_v    <= i_s_axis_tvalid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_out_v <= w_v[W];
        end
    end

    // operand capture, halves joined high over low
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode <= t_mode'(i_s_axis_tuser);
            r1_a    <= {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
            r1_b    <= {i_s_axis_tdata[191:128], i_s_axis_tdata[255:192]};
            r1_amt  <= i_s_axis_tdata[263:256];
        end
    end

    // simple results, divide set-up and partial products
    always_comb begin
        logic [2*W-1:0] v_rot;
        logic           v_sa;
        logic           v_sb;
        v_sa          = r1_a[W-1];
        v_sb          = r1_b[W-1];
        n2_rec        = '0;
        n2_rec.mode   = r1_mode;
        n2_rec.q      = v_sa ? (~r1_a + W'(1)) : r1_a;
        n2_rec.m      = v_sb ? (~r1_b + W'(1)) : r1_b;
        n2_rec.neg    = v_sa ^ v_sb;
        v_rot         = '0;
        case (r1_mode)
            MODE_ADD: n2_rec.res = r1_a + r1_b;
            MODE_SUB: n2_rec.res = r1_a - r1_b;
            MODE_DIV: n2_rec.dz  = (r1_b == '0);
            MODE_AND: n2_rec.res = r1_a & r1_b;
            MODE_OR:  n2_rec.res = r1_a | r1_b;
            MODE_XOR: n2_rec.res = r1_a ^ r1_b;
            MODE_NOT: n2_rec.res = ~r1_a;
            MODE_SHL: n2_rec.res = r1_a << r1_amt;
            MODE_SHR: n2_rec.res = r1_a >> r1_amt;
            MODE_ROL: begin
                v_rot      = {r1_a, r1_a} << r1_amt[6:0];
                n2_rec.res = v_rot[2*W-1:W];
            end
            MODE_ROR: begin
                v_rot      = {r1_a, r1_a} >> r1_amt[6:0];
                n2_rec.res = v_rot[W-1:0];
            end
            MODE_CMP: begin
                n2_rec.lt = $signed(r1_a) < $signed(r1_b);
                n2_rec.eq = (r1_a == r1_b);
                n2_rec.gt = $signed(r1_a) > $signed(r1_b);
            end
            default: n2_rec.res = '0;
        endcase
        // only products that land below bit 128
        n2_p[0] = r1_a[31:0]  * r1_b[31:0];
        n2_p[1] = r1_a[31:0]  * r1_b[63:32];
        n2_p[2] = r1_a[63:32] * r1_b[31:0];
        n2_p[3] = r1_a[31:0]  * r1_b[95:64];
        n2_p[4] = r1_a[63:32] * r1_b[63:32];
        n2_p[5] = r1_a[95:64] * r1_b[31:0];
        n2_p[6] = r1_a[31:0]  * r1_b[127:96];
        n2_p[7] = r1_a[63:32] * r1_b[95:64];
        n2_p[8] = r1_a[95:64] * r1_b[63:32];
        n2_p[9] = r1_a[127:96] * r1_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rec <= n2_rec;
            r2_p   <= n2_p;
        end
    end

    // group products by weight, top group needs its low word only
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rec <= r2_rec;
            r3_s0  <= r2_p[0];
            r3_s1  <= {1'b0, r2_p[1]} + {1'b0, r2_p[2]};
            r3_s2  <= {2'b0, r2_p[3]} + {2'b0, r2_p[4]} + {2'b0, r2_p[5]};
            r3_s3  <= r2_p[6][31:0] + r2_p[7][31:0] + r2_p[8][31:0] + r2_p[9][31:0];
        end
    end

    assign n4_prod = {64'b0, r3_s0} + {31'b0, r3_s1, 32'b0}
                   + {r3_s2[63:0], 64'b0} + {r3_s3, 96'b0};

    // product replaces the result word in multiply mode
    always_comb begin
        n4_rec = r3_rec;
        if (r3_rec.mode == MODE_MUL) begin
            n4_rec.res = n4_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_rec <= n4_rec;
        end
    end

    // divide chain, one iteration per stage
    assign w_v[0]   = r4_v;
    assign w_rec[0] = r4_rec;

    for (genvar k = 0; k < W; k++) begin : g_div
        salu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[k]),
            .i_rec   (w_rec[k]),
            .o_valid (w_v[k+1]),
            .o_rec   (w_rec[k+1])
        );
    end

    // quotient takes the sign rule, zero divisor already gave all ones
    always_comb begin
        n_out_res = w_rec[W].res;
        if (w_rec[W].mode == MODE_DIV) begin
            n_out_res = w_rec[W].neg ? (~w_rec[W].q + W'(1)) : w_rec[W].q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {n_out_res[63:0], n_out_res[127:64]};
            r_out_user <= {w_rec[W].dz, w_rec[W].gt, w_rec[W].eq, w_rec[W].lt};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // compare flags never more than one
    `SALU_ASSERT(a_cmp_flags, !o_m_axis_tvalid || $onehot0(o_m_axis_tuser[2:0]))
    // divide flag never with compare flags
    `SALU_ASSERT(a_dz_alone, !(o_m_axis_tvalid && o_m_axis_tuser[3] && (|o_m_axis_tuser[2:0])))
    // a stalled result beat holds through the stall
    `SALU_ASSERT_NEXT(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

endmodule

// File: sim/salu_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// salu_checker
// watches both streams of the alu, predicts each result and compares it
// ---------------------------------------------------------------------------
module salu_checker
    import salu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [263:0] i_s_tdata,
    input  logic [3:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,
    input  logic [3:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic [127:0] word;
        logic         lt;
        logic         eq;
        logic         gt;
        logic         dz;
    } t_alu_result;

    t_alu_result result_q[$];

    function automatic t_alu_result compute_result(logic [3:0] mode, logic [127:0] a,
                                                   logic [127:0] b, logic [7:0] amt);
        t_alu_result r;
        logic [127:0] ma, mb, q;
        int unsigned  k;
        r = '{word: '0, lt: 1'b0, eq: 1'b0, gt: 1'b0, dz: 1'b0};
        k = amt % 128;
        case (mode)
            MODE_ADD: r.word = a + b;
            MODE_SUB: r.word = a - b;
            MODE_MUL: r.word = a * b;
            MODE_DIV: begin
                ma = a[127] ? -a : a;
                mb = b[127] ? -b : b;
                // zero divisor leaves an all-ones magnitude
                q = (mb == '0) ? '1 : ma / mb;
                r.word = (a[127] ^ b[127]) ? -q : q;
                r.dz = (b == '0);
            end
            MODE_AND: r.word = a & b;
            MODE_OR:  r.word = a | b;
            MODE_XOR: r.word = a ^ b;
            MODE_NOT: r.word = ~a;
            MODE_SHL: r.word = (amt >= 128) ? '0 : a << amt;
            MODE_SHR: r.word = (amt >= 128) ? '0 : a >> amt;
            MODE_ROL: r.word = (k == 0) ? a : (a << k) | (a >> (128 - k));
            MODE_ROR: r.word = (k == 0) ? a : (a >> k) | (a << (128 - k));
            MODE_CMP: begin
                r.lt = $signed(a) < $signed(b);
                r.eq = (a == b);
                r.gt = $signed(a) > $signed(b);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alu_result e;
        logic [127:0] act_word;
        if (!i_rst_n) begin
            result_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                result_q.push_back(compute_result(i_s_tuser,
                    {i_s_tdata[63:0], i_s_tdata[127:64]},
                    {i_s_tdata[191:128], i_s_tdata[255:192]}, i_s_tdata[263:256]));
            if (i_m_tvalid && i_m_tready) begin
                act_word = {i_m_tdata[63:0], i_m_tdata[127:64]};
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", act_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = result_q.pop_front();
                    if (act_word !== e.word || i_m_tuser !== {e.dz, e.gt, e.eq, e.lt}) begin
                        o_fail_count <= o_fail_count + 1;
                        if (act_word[127:64] !== e.word[127:64])
                            $error("result_hi expected %h actual %h", e.word[127:64],
                                   act_word[127:64]);
                        if (act_word[63:0] !== e.word[63:0])
                            $error("result_lo expected %h actual %h", e.word[63:0],
                                   act_word[63:0]);
                        if (i_m_tuser[0] !== e.lt)
                            $error("less expected %b actual %b", e.lt, i_m_tuser[0]);
                        if (i_m_tuser[1] !== e.eq)
                            $error("equal expected %b actual %b", e.eq, i_m_tuser[1]);
                        if (i_m_tuser[2] !== e.gt)
                            $error("greater expected %b actual %b", e.gt, i_m_tuser[2]);
                        if (i_m_tuser[3] !== e.dz)
                            $error("divide_by_zero expected %b actual %b", e.dz,
                                   i_m_tuser[3]);
                    end
                end
            end
            o_pending <= result_q.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// drives directed and random alu beats with random idling on both sides
// ---------------------------------------------------------------------------
module tb;
    import salu_pkg::*;

    localparam int N_RANDOM   = 1725;
    localparam int DRAIN_WAIT = 160;   // pipe is 133 deep
    localparam int WDOG_LIMIT = 3000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [263:0] s_tdata = '0;   // a_hi, a_lo, b_hi, b_lo, shift_amount
    logic [3:0]   s_tuser = '0;   // mode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // result_hi, result_lo
    logic [3:0]   m_tuser;        // less, equal, greater, divide_by_zero
    int           fail_count;
    int           pending;
    int           idle_cnt;
    int           stall_cnt = 0;
    bit           src_idle_on = 1'b1;
    bit           snk_idle_on = 1'b1;
    int           n_sent = 0;

    localparam logic [127:0] MOST_NEG = {1'b1, 127'b0};
    localparam logic [127:0] ALL_ONES = '1;

    always #5 i_clk = ~i_clk;

    signed_128bit_alu_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    salu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sink: random stall before each result beat
    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) begin
            stall_cnt = snk_idle_on ? $urandom_range(0, 11) : 0;
        end else if (stall_cnt > 0) begin
            stall_cnt = stall_cnt - 1;
        end
        m_tready <= i_rst_n && (stall_cnt == 0);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WDOG_LIMIT);
            $display("signed_128bit_alu_top verification failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // one input beat, with a random gap in front of it
    task automatic send_op(logic [3:0] mode, logic [127:0] a, logic [127:0] b,
                           logic [7:0] amt);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {amt, b[63:0], b[127:64], a[63:0], a[127:64]};
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
    endtask

    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [127:0] rand_word();
        logic [127:0] w;
        w = {rand_half(), rand_half()};
        // short values now and then, sign extended, so division gets real quotients
        if ($urandom_range(0, 3) == 0)
            w = {{96{w[31]}}, w[31:0]};
        return w;
    endfunction

    initial begin
        logic [3:0]   m;
        logic [127:0] a, b;
        logic [7:0]   amt;
        int           kind;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and corner cases
        send_op(MODE_ADD, ALL_ONES, 128'd1, 8'd0);
        send_op(MODE_ADD, MOST_NEG - 1, 128'd1, 8'd0);
        send_op(MODE_SUB, MOST_NEG, 128'd1, 8'd0);
        send_op(MODE_SUB, 128'd0, ALL_ONES, 8'd0);
        send_op(MODE_MUL, ALL_ONES, ALL_ONES, 8'd0);
        send_op(MODE_MUL, MOST_NEG, 128'd3, 8'd0);
        send_op(MODE_DIV, 128'd100, 128'd0, 8'd0);        // zero divisor, positive
        send_op(MODE_DIV, -128'd100, 128'd0, 8'd0);       // zero divisor, negative
        send_op(MODE_DIV, MOST_NEG, ALL_ONES, 8'd0);      // most negative over -1
        send_op(MODE_DIV, -128'd7, 128'd2, 8'd0);
        send_op(MODE_AND, ALL_ONES, 128'h5555, 8'd0);
        send_op(MODE_OR, 128'd0, MOST_NEG, 8'd0);
        send_op(MODE_XOR, ALL_ONES, ALL_ONES, 8'd0);
        send_op(MODE_NOT, 128'd0, ALL_ONES, 8'd0);
        send_op(MODE_SHL, ALL_ONES, 128'd0, 8'd128);
        send_op(MODE_SHL, 128'd1, 128'd0, 8'd127);
        send_op(MODE_SHR, ALL_ONES, 128'd0, 8'd64);
        send_op(MODE_SHR, ALL_ONES, 128'd0, 8'd0);
        send_op(MODE_ROL, MOST_NEG + 1, 128'd0, 8'd128);  // rotate wraps to a zero amount
        send_op(MODE_ROR, 128'd1, 128'd0, 8'd1);
        send_op(MODE_CMP, MOST_NEG, 128'd1, 8'd0);
        send_op(MODE_CMP, ALL_ONES, ALL_ONES, 8'd0);
        send_op(MODE_CMP, 128'd5, ALL_ONES, 8'd0);
        send_op(4'd13, ALL_ONES, ALL_ONES, 8'd255);       // unused modes read zero
        send_op(4'd15, ALL_ONES, ALL_ONES, 8'd128);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 250 == 0) begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == N_RANDOM / 2) begin
                // hold off until the pipe has drained completely
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            kind = $urandom_range(0, 19);
            m = (kind == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
            a = rand_word();
            b = ($urandom_range(0, 15) == 0) ? 128'd0 : rand_word();
            if ($urandom_range(0, 7) == 0)
                b = a;
            amt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 128));
            if (m < MODE_SHL || m > MODE_ROR)
                amt = 8'($urandom_range(0, 255));
            send_op(m, a, b, amt);
        end
        s_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d beats over all thirteen modes plus unused codes,", n_sent);
        $display("with random gaps, sink stalls and one full drain mid-run");
        if (fail_count == 0 && pending == 0) begin
            $display("signed_128bit_alu_top verification clean");
        end else begin
            $display("signed_128bit_alu_top verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/salu_pkg.sv
rtl/salu_div_step.sv
rtl/signed_128bit_alu_top.sv
sim/salu_checker.sv
sim/tb.sv
